// ===== hw/rtl/complex_matrix_vector_product_assert.svh =====
// Assertion macros for the complex matrix-vector product block.
// Used by the port checker; no other dependencies.
`ifndef COMPLEX_MATRIX_VECTOR_PRODUCT_ASSERT_SVH
`define COMPLEX_MATRIX_VECTOR_PRODUCT_ASSERT_SVH

// Same-cycle implication, checked at each rising edge outside reset
`define CMVP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmvp check failed: same-cycle rule");

// Next-cycle implication, checked at each rising edge outside reset
`define CMVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmvp check failed: next-cycle rule");

`endif

// ===== hw/rtl/cmvp_pkg.sv =====
// Shared constants, codes and types for the complex matrix-vector product.
// No dependencies; the interfaces, the top level and the checker import it.
`default_nettype none

package cmvp_pkg;

   localparam int MAX_DIM_DEF   = 16;
   localparam int DATA_BITS_DEF = 16;
   localparam int ACC_BITS      = 37;
   localparam int IDX_BITS      = 4;
   localparam int CFG_BITS      = 5;
   localparam int PADDR_BITS    = 4;
   localparam int PDATA_BITS    = 32;

   localparam logic [CFG_BITS-1:0] DIM_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_LOAD_VECTOR = 2'd0,
      OP_MATRIX_ELEM = 2'd1,
      OP_EMIT        = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_ROW_COUNT = 2'd0,
      REG_COL_COUNT = 2'd1,
      REG_TRANSPOSE = 2'd2,
      REG_CONJUGATE = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_ACC,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cmvp_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on cmvp_pkg for field widths.
`default_nettype none

interface cmvp_req_if #(
   parameter int DATA_BITS = cmvp_pkg::DATA_BITS_DEF
);
   import cmvp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [IDX_BITS-1:0]         vector_index;
   logic [IDX_BITS-1:0]         row_index;
   logic [IDX_BITS-1:0]         col_index;
   logic signed [DATA_BITS-1:0] value_re;
   logic signed [DATA_BITS-1:0] value_im;

   modport source (
      output valid, opcode, vector_index, row_index, col_index, value_re, value_im,
      input  ready
   );
   modport sink (
      input  valid, opcode, vector_index, row_index, col_index, value_re, value_im,
      output ready
   );
endinterface

interface cmvp_rsp_if;
   import cmvp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [IDX_BITS-1:0]        out_index;
   logic signed [ACC_BITS-1:0] out_re;
   logic signed [ACC_BITS-1:0] out_im;
   logic                       last;

   modport source (output valid, out_index, out_re, out_im, last, input ready);
   modport sink   (input  valid, out_index, out_re, out_im, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/complex_matrix_vector_product.sv =====
// Complex matrix-vector product, top level.
// Depends on cmvp_pkg, cmvp_if (channel interfaces) and cmvp_ram.
//
// Usage: request words arrive on req_bus (valid/ready). Opcode 0 stores a
// vector element, opcode 1 folds one matrix element times the matching
// vector element into an accumulator, opcode 2 streams the result vector
// on rsp_bus with last on its final word and clears the accumulators.
// Opcode 3 and out-of-range elements are dropped.
// Sequencing: an opcode-0 word is stored and the block stays ready. An
// opcode-1 word passes through the multiplier and adder stages (ST_MUL,
// ST_SUM) and the accumulator read-modify-write (ST_ACC) before the next word is taken.
// An opcode-2 word gives each result by an accumulator read, held while the
// output register is stalled, then a load of the output register.
// The APB port (csr_*) writes sizes and modes; pready is always high.
// Reset restores sizes to 16 and both modes to 0, and empties the
// accumulators at once through per-entry valid bits; the vector store holds
// nothing until written.
// A stalled receiver holds the result word in the output register and
// pauses the result stream; request words are taken again once the stream
// has loaded its last word.
`default_nettype none

module complex_matrix_vector_product #(
   parameter int MAX_DIM   = cmvp_pkg::MAX_DIM_DEF,
   parameter int DATA_BITS = cmvp_pkg::DATA_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   cmvp_req_if.sink                          req_bus,
   cmvp_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cmvp_pkg::PADDR_BITS-1:0]   csr_paddr,
   input  logic [cmvp_pkg::PDATA_BITS-1:0]   csr_pwdata,
   output logic [cmvp_pkg::PDATA_BITS-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import cmvp_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_DIM);
   localparam int PROD_BITS = 2 * DATA_BITS;
   localparam int EXT_BITS  = (PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS;
   localparam int VEC_WIDTH = 2 * DATA_BITS;
   localparam int ACC_WIDTH = 2 * ACC_BITS;

   // Configuration registers
   logic [CFG_BITS-1:0] row_count_ff, row_count_in;
   logic [CFG_BITS-1:0] col_count_ff, col_count_in;
   logic                transpose_ff, transpose_in;
   logic                conjugate_ff, conjugate_in;

   // Control state
   state_type           state_ff, state_in;
   logic [CFG_BITS-1:0] k_ff, k_in;
   logic [CFG_BITS-1:0] len_ff, len_in;
   logic [MAX_DIM-1:0]  acc_valid_ff, acc_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic signed [DATA_BITS-1:0] ar_ff, ar_in;
   logic signed [DATA_BITS-1:0] ai_ff, ai_in;
   logic [ADDR_BITS-1:0]        acc_addr_ff, acc_addr_in;
   logic [ACC_BITS-1:0]         prod_rr_ff, prod_rr_in;
   logic [ACC_BITS-1:0]         prod_ii_ff, prod_ii_in;
   logic [ACC_BITS-1:0]         prod_ri_ff, prod_ri_in;
   logic [ACC_BITS-1:0]         prod_ir_ff, prod_ir_in;
   logic [ACC_BITS-1:0]         sum_re_ff, sum_re_in;
   logic [ACC_BITS-1:0]         sum_im_ff, sum_im_in;
   logic [IDX_BITS-1:0]         rsp_index_ff, rsp_index_in;
   logic [ACC_BITS-1:0]         rsp_re_ff, rsp_re_in;
   logic [ACC_BITS-1:0]         rsp_im_ff, rsp_im_in;
   logic                        rsp_last_ff, rsp_last_in;

   // Decoded request
   op_type              op;
   logic                is_load, is_matrix, is_emit;
   logic [CFG_BITS-1:0] rows, cols, len_calc;
   logic                in_range, vec_ok;
   logic [IDX_BITS-1:0] acc_sel, vec_sel;

   // Control outputs
   logic                 req_ready;
   logic                 vec_we, vec_re;
   logic                 acc_re, acc_we;
   logic [ADDR_BITS-1:0] acc_raddr;
   logic                 load_rsp, clear_valid, start_emit;
   logic                 slot_free, emit_last;
   logic                 csr_write;
   reg_type              csr_reg;

   // Memory data
   logic [VEC_WIDTH-1:0]        vec_rd_data;
   logic [ACC_WIDTH-1:0]        acc_rd_data, acc_wr_data;
   logic signed [DATA_BITS-1:0] xr, xi;
   logic signed [PROD_BITS-1:0] p_rr, p_ii, p_ri, p_ir;
   logic [ACC_BITS-1:0]         acc_old_re, acc_old_im;
   logic                        old_valid;

   // Vector store: {imag, real}
   cmvp_ram #(
      .WIDTH (VEC_WIDTH),
      .DEPTH (MAX_DIM)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (ADDR_BITS'(req_bus.vector_index)),
      .wr_data ({req_bus.value_im, req_bus.value_re}),
      .rd_en   (vec_re),
      .rd_addr (ADDR_BITS'(vec_sel)),
      .rd_data (vec_rd_data)
   );

   // Accumulator store: {imag, real}
   cmvp_ram #(
      .WIDTH (ACC_WIDTH),
      .DEPTH (MAX_DIM)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_addr_ff),
      .wr_data (acc_wr_data),
      .rd_en   (acc_re),
      .rd_addr (acc_raddr),
      .rd_data (acc_rd_data)
   );

   // Decode request and clamp sizes
   always_comb begin
      op        = op_type'(req_bus.opcode);
      is_load   = (op == OP_LOAD_VECTOR);
      is_matrix = (op == OP_MATRIX_ELEM);
      is_emit   = (op == OP_EMIT);
      rows      = (32'(row_count_ff) > 32'(MAX_DIM)) ? CFG_BITS'(MAX_DIM) : row_count_ff;
      cols      = (32'(col_count_ff) > 32'(MAX_DIM)) ? CFG_BITS'(MAX_DIM) : col_count_ff;
      len_calc  = transpose_ff ? cols : rows;
      in_range  = (CFG_BITS'(req_bus.row_index) < rows) &&
                  (CFG_BITS'(req_bus.col_index) < cols);
      vec_ok    = 32'(req_bus.vector_index) < 32'(MAX_DIM);
      acc_sel   = transpose_ff ? req_bus.col_index : req_bus.row_index;
      vec_sel   = transpose_ff ? req_bus.row_index : req_bus.col_index;
      slot_free = !rsp_valid_ff || rsp_bus.ready;
      emit_last = (CFG_BITS'(k_ff + 1'b1) == len_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               priority if (is_matrix && in_range) begin
                  state_in = ST_MUL;
               end else if (is_emit && len_calc != '0) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL:     state_in = ST_SUM;
         ST_SUM:     state_in = ST_ACC;
         ST_ACC:     state_in = ST_IDLE;
         ST_EMIT_RD: begin
            if (slot_free) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready   = 1'b0;
      vec_we      = 1'b0;
      vec_re      = 1'b0;
      acc_re      = 1'b0;
      acc_we      = 1'b0;
      acc_raddr   = ADDR_BITS'(acc_sel);
      load_rsp    = 1'b0;
      clear_valid = 1'b0;
      start_emit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               vec_we      = is_load && vec_ok;
               vec_re      = is_matrix && in_range;
               acc_re      = is_matrix && in_range;
               start_emit  = is_emit;
               clear_valid = is_emit && (len_calc == '0);
            end
         end
         ST_MUL, ST_SUM: begin
         end
         ST_ACC: begin
            acc_we = 1'b1;
         end
         ST_EMIT_RD: begin
            acc_re    = slot_free;
            acc_raddr = ADDR_BITS'(k_ff);
         end
         ST_EMIT_LD: begin
            load_rsp    = 1'b1;
            clear_valid = emit_last;
         end
         default: begin
         end
      endcase
   end

   // Complex multiply: sign-extend or wrap each product into accumulator width
   assign xr   = vec_rd_data[DATA_BITS-1:0];
   assign xi   = vec_rd_data[VEC_WIDTH-1:DATA_BITS];
   assign p_rr = ar_ff * xr;
   assign p_ii = ai_ff * xi;
   assign p_ri = ar_ff * xi;
   assign p_ir = ai_ff * xr;

   // Accumulate; an entry without its valid bit reads as zero
   assign old_valid   = acc_valid_ff[acc_addr_ff];
   assign acc_old_re  = old_valid ? acc_rd_data[ACC_BITS-1:0] : '0;
   assign acc_old_im  = old_valid ? acc_rd_data[ACC_WIDTH-1:ACC_BITS] : '0;
   assign acc_wr_data = {acc_old_im + sum_im_ff, acc_old_re + sum_re_ff};

   // Register next values
   always_comb begin
      csr_write    = csr_psel && csr_penable && csr_pwrite;
      csr_reg      = reg_type'(csr_paddr[3:2]);
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      transpose_in = transpose_ff;
      conjugate_in = conjugate_ff;
      if (csr_write) begin
         unique case (csr_reg)
            REG_ROW_COUNT: row_count_in = csr_pwdata[CFG_BITS-1:0];
            REG_COL_COUNT: col_count_in = csr_pwdata[CFG_BITS-1:0];
            REG_TRANSPOSE: transpose_in = csr_pwdata[0];
            REG_CONJUGATE: conjugate_in = csr_pwdata[0];
            default: begin
            end
         endcase
      end

      k_in   = start_emit ? '0 : (load_rsp ? CFG_BITS'(k_ff + 1'b1) : k_ff);
      len_in = start_emit ? len_calc : len_ff;

      acc_valid_in = acc_valid_ff;
      if (clear_valid) begin
         acc_valid_in = '0;
      end else if (acc_we) begin
         acc_valid_in[acc_addr_ff] = 1'b1;
      end

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_bus.ready);

      // Capture operands on acceptance
      ar_in       = req_bus.valid && req_ready ? req_bus.value_re : ar_ff;
      ai_in       = req_bus.valid && req_ready ? req_bus.value_im : ai_ff;
      acc_addr_in = req_bus.valid && req_ready ? ADDR_BITS'(acc_sel) : acc_addr_ff;

      prod_rr_in = prod_rr_ff;
      prod_ii_in = prod_ii_ff;
      prod_ri_in = prod_ri_ff;
      prod_ir_in = prod_ir_ff;
      if (state_ff == ST_MUL) begin
         prod_rr_in = ACC_BITS'(EXT_BITS'(p_rr));
         prod_ii_in = ACC_BITS'(EXT_BITS'(p_ii));
         prod_ri_in = ACC_BITS'(EXT_BITS'(p_ri));
         prod_ir_in = ACC_BITS'(EXT_BITS'(p_ir));
      end

      sum_re_in = sum_re_ff;
      sum_im_in = sum_im_ff;
      if (state_ff == ST_SUM) begin
         sum_re_in = conjugate_ff ? prod_rr_ff + prod_ii_ff : prod_rr_ff - prod_ii_ff;
         sum_im_in = conjugate_ff ? prod_ri_ff - prod_ir_ff : prod_ri_ff + prod_ir_ff;
      end

      rsp_index_in = rsp_index_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_rsp) begin
         rsp_index_in = IDX_BITS'(k_ff);
         rsp_re_in    = acc_valid_ff[ADDR_BITS'(k_ff)] ? acc_rd_data[ACC_BITS-1:0] : '0;
         rsp_im_in    = acc_valid_ff[ADDR_BITS'(k_ff)] ?
                        acc_rd_data[ACC_WIDTH-1:ACC_BITS] : '0;
         rsp_last_in  = emit_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_RESET;
         col_count_ff <= DIM_RESET;
         transpose_ff <= 1'b0;
         conjugate_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         len_ff       <= '0;
         acc_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         transpose_ff <= transpose_in;
         conjugate_ff <= conjugate_in;
         state_ff     <= state_in;
         k_ff         <= k_in;
         len_ff       <= len_in;
         acc_valid_ff <= acc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ar_ff        <= ar_in;
      ai_ff        <= ai_in;
      acc_addr_ff  <= acc_addr_in;
      prod_rr_ff   <= prod_rr_in;
      prod_ii_ff   <= prod_ii_in;
      prod_ri_ff   <= prod_ri_in;
      prod_ir_ff   <= prod_ir_in;
      sum_re_ff    <= sum_re_in;
      sum_im_ff    <= sum_im_in;
      rsp_index_ff <= rsp_index_in;
      rsp_re_ff    <= rsp_re_in;
      rsp_im_ff    <= rsp_im_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Register readback
   always_comb begin
      unique case (csr_reg)
         REG_ROW_COUNT: csr_prdata = PDATA_BITS'(row_count_ff);
         REG_COL_COUNT: csr_prdata = PDATA_BITS'(col_count_ff);
         REG_TRANSPOSE: csr_prdata = PDATA_BITS'(transpose_ff);
         REG_CONJUGATE: csr_prdata = PDATA_BITS'(conjugate_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready        = 1'b1;
   assign req_bus.ready     = req_ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_index = rsp_index_ff;
   assign rsp_bus.out_re    = rsp_re_ff;
   assign rsp_bus.out_im    = rsp_im_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cmvp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cmvp_ram #(
   parameter  int WIDTH     = 32,
   parameter  int DEPTH     = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold data until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cmvp_checker.sv =====
// Port-level checks for the complex matrix-vector product, bound to the top.
// Depends on cmvp_pkg and complex_matrix_vector_product_assert.svh.
`default_nettype none

`include "complex_matrix_vector_product_assert.svh"

module cmvp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_last,
   input logic [cmvp_pkg::IDX_BITS-1:0]       rsp_out_index,
   input logic [cmvp_pkg::ACC_BITS-1:0]       rsp_out_re,
   input logic [cmvp_pkg::ACC_BITS-1:0]       rsp_out_im,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [cmvp_pkg::PADDR_BITS-1:0]     csr_paddr,
   input logic [cmvp_pkg::PDATA_BITS-1:0]     csr_pwdata,
   input logic [cmvp_pkg::PDATA_BITS-1:0]     csr_prdata
);
   import cmvp_pkg::*;

   // A stalled result word holds
   `CMVP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_re) && $stable(rsp_out_im) && $stable(rsp_out_index) && $stable(rsp_last))

   // The word after a taken last word never follows directly
   `CMVP_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid)

   // A row count write reads back in the next cycle
   `CMVP_ASSERT_NEXT(a_row_count_readback, clock, reset, csr_psel && csr_penable && csr_pwrite && reg_type'(csr_paddr[3:2]) == REG_ROW_COUNT, reg_type'(csr_paddr[3:2]) != REG_ROW_COUNT || csr_prdata[CFG_BITS-1:0] == $past(csr_pwdata[CFG_BITS-1:0]))

   // No result word right after reset
   `CMVP_ASSERT_SAME(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind complex_matrix_vector_product cmvp_checker u_cmvp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_last      (rsp_bus.last),
   .rsp_out_index (rsp_bus.out_index),
   .rsp_out_re    (rsp_bus.out_re),
   .rsp_out_im    (rsp_bus.out_im),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);

`default_nettype wire
